### sv/lzwd_pkg.sv
package lzwd_pkg;

	localparam int MAX_CODE_BITS = 12;
	localparam int TABLE_DEPTH   = 4096;
	localparam int ROOT_BITS     = 8;

	localparam int TABLE_AW = $clog2(TABLE_DEPTH);
	localparam int CODE_W   = MAX_CODE_BITS;
	localparam int ENTRY_W  = TABLE_AW + 1;
	localparam int BYTE_W   = 8;
	localparam int BUF_W    = 24;
	localparam int CNT_W    = 5;
	localparam int WIDTH_W  = 4;

	localparam logic [ENTRY_W-1:0] CLR_CODE   = ENTRY_W'(1 << ROOT_BITS);
	localparam logic [ENTRY_W-1:0] END_CODE   = ENTRY_W'((1 << ROOT_BITS) + 1);
	localparam logic [ENTRY_W-1:0] FIRST_FREE = ENTRY_W'((1 << ROOT_BITS) + 2);
	localparam logic [ENTRY_W-1:0] TABLE_FULL = ENTRY_W'(TABLE_DEPTH);

	localparam logic [WIDTH_W-1:0] START_WIDTH = WIDTH_W'(ROOT_BITS + 1);
	localparam logic [WIDTH_W-1:0] MAX_WIDTH   = WIDTH_W'(MAX_CODE_BITS);

	// a push is refused once fewer than one byte of room is left
	localparam logic [CNT_W-1:0] FILL_LIMIT = CNT_W'(BUF_W - BYTE_W);
	localparam logic [CNT_W-1:0] BYTE_BITS  = CNT_W'(BYTE_W);

	typedef enum logic {
		OP_PUSH = 1'b0,
		OP_PULL = 1'b1
	} op_t;

	typedef enum logic [2:0] {
		ST_TAKEN   = 3'd0,
		ST_REFUSED = 3'd1,
		ST_PIXEL   = 3'd2,
		ST_NEED    = 3'd3,
		ST_END     = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_PULL,
		S_WALK,
		S_POP,
		S_EMIT
	} state_t;

	typedef struct packed {
		logic [CODE_W-1:0] prefix;
		logic [BYTE_W-1:0] suffix;
	} entry_t;

	localparam int ENTRY_BITS = $bits(entry_t);

endpackage

### sv/lzwd_ram.sv
module lzwd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

### sv/lzw_variable_width_decoder.sv
// LZW decoder for GIF-style streams: 8-bit roots, clear code 256, end code 257,
// codes packed LSB first, 9 to 12 bits wide.
// Input channel (in_valid / in_stall): operation 0 pushes data_byte into a
// 24-bit bit buffer, operation 1 requests the next decoded pixel. Every request
// gives exactly one result on the output channel (out_valid / out_stall):
// status and pixel_index.
// A push's result is registered at the accepting edge when the output
// register is free. A pixel taken from the string stack goes through the stack
// memory read, then the output register; no new request is taken until that
// result is out (in_stall). A request that must decode a new code first takes
// the code from the bit buffer, then walks the prefix chain in the code table
// memory, one string character per step, then pops a pixel as above.
// The chain walk is bound by the registered read of the table memory.
// Reset is immediate: roots are produced by logic, so the table needs no
// clearing pass and the first request may follow reset in the next cycle.
// While the receiver stalls, a finished result holds in the output register;
// one more request is taken and worked, and its result parks in a holding
// register until the output frees up.
module lzw_variable_width_decoder
	import lzwd_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              operation,
	input  logic [BYTE_W-1:0] data_byte,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [2:0]        status,
	output logic [BYTE_W-1:0] pixel_index
);

	state_t              state_q, state_d;
	logic [BUF_W-1:0]    bit_buf_q, bit_buf_d;
	logic [CNT_W-1:0]    bit_cnt_q, bit_cnt_d;
	logic [WIDTH_W-1:0]  code_width_q, code_width_d;
	logic [ENTRY_W-1:0]  next_entry_q, next_entry_d;
	logic [CODE_W-1:0]   prev_code_q, prev_code_d;
	logic [BYTE_W-1:0]   prev_first_q, prev_first_d;
	logic                after_clear_q, after_clear_d;
	logic                stream_ended_q, stream_ended_d;
	logic [ENTRY_W-1:0]  stack_cnt_q, stack_cnt_d;
	logic                out_valid_q, out_valid_d;

	logic [CODE_W-1:0]   code_q, code_d;
	logic [CODE_W-1:0]   walk_addr_q, walk_addr_d;
	status_t             res_status_q, res_status_d;
	logic [BYTE_W-1:0]   res_pixel_q, res_pixel_d;
	status_t             status_q, status_d;
	logic [BYTE_W-1:0]   pixel_q, pixel_d;

	logic                tbl_we, tbl_re;
	logic [TABLE_AW-1:0] tbl_waddr, tbl_raddr;
	entry_t              tbl_wdata, tbl_rdata;
	logic                stk_we, stk_re;
	logic [TABLE_AW-1:0] stk_waddr, stk_raddr;
	logic [BYTE_W-1:0]   stk_wdata, stk_rdata;

	logic                out_free;
	logic                emit;
	status_t             emit_status;
	logic [BYTE_W-1:0]   emit_pixel;
	logic [CODE_W-1:0]   code_mask;
	logic [CODE_W-1:0]   code;
	logic [ENTRY_W-1:0]  code_ext;
	logic                walk_root;
	logic [BYTE_W-1:0]   walk_suffix;

	lzwd_ram #(
		.WIDTH(ENTRY_BITS),
		.DEPTH(TABLE_DEPTH)
	) u_table (
		.clk    (clk),
		.wr_en  (tbl_we),
		.wr_addr(tbl_waddr),
		.wr_data(tbl_wdata),
		.rd_en  (tbl_re),
		.rd_addr(tbl_raddr),
		.rd_data(tbl_rdata)
	);

	lzwd_ram #(
		.WIDTH(BYTE_W),
		.DEPTH(TABLE_DEPTH)
	) u_stack (
		.clk    (clk),
		.wr_en  (stk_we),
		.wr_addr(stk_waddr),
		.wr_data(stk_wdata),
		.rd_en  (stk_re),
		.rd_addr(stk_raddr),
		.rd_data(stk_rdata)
	);

	assign in_stall    = (state_q != S_IDLE);
	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign pixel_index = pixel_q;

	always_comb begin
		state_d        = state_q;
		bit_buf_d      = bit_buf_q;
		bit_cnt_d      = bit_cnt_q;
		code_width_d   = code_width_q;
		next_entry_d   = next_entry_q;
		prev_code_d    = prev_code_q;
		prev_first_d   = prev_first_q;
		after_clear_d  = after_clear_q;
		stream_ended_d = stream_ended_q;
		stack_cnt_d    = stack_cnt_q;
		out_valid_d    = out_valid_q;
		code_d         = code_q;
		walk_addr_d    = walk_addr_q;
		res_status_d   = res_status_q;
		res_pixel_d    = res_pixel_q;
		status_d       = status_q;
		pixel_d        = pixel_q;

		tbl_we    = 1'b0;
		tbl_waddr = '0;
		tbl_wdata = '0;
		tbl_re    = 1'b0;
		tbl_raddr = '0;
		stk_we    = 1'b0;
		stk_waddr = '0;
		stk_wdata = '0;
		stk_re    = 1'b0;
		stk_raddr = '0;

		emit        = 1'b0;
		emit_status = ST_TAKEN;
		emit_pixel  = '0;

		out_free  = !out_valid_q || !out_stall;
		code_mask = {CODE_W{1'b1}} >> (MAX_WIDTH - code_width_q);
		code      = bit_buf_q[CODE_W-1:0] & code_mask;
		code_ext  = ENTRY_W'(code);
		// codes below the first free entry are roots and never live in the table
		walk_root   = (ENTRY_W'(walk_addr_q) < FIRST_FREE);
		walk_suffix = walk_root ? walk_addr_q[BYTE_W-1:0] : tbl_rdata.suffix;

		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					if (operation == OP_PUSH) begin
						emit = 1'b1;
						if (bit_cnt_q > FILL_LIMIT) begin
							emit_status = ST_REFUSED;
						end else begin
							bit_buf_d   = bit_buf_q | (BUF_W'(data_byte) << bit_cnt_q);
							bit_cnt_d   = bit_cnt_q + BYTE_BITS;
							emit_status = ST_TAKEN;
						end
					end else if (stack_cnt_q != '0) begin
						stk_re      = 1'b1;
						stk_raddr   = TABLE_AW'(stack_cnt_q - ENTRY_W'(1));
						stack_cnt_d = stack_cnt_q - ENTRY_W'(1);
						state_d     = S_POP;
					end else begin
						state_d = S_PULL;
					end
				end
			end
			S_PULL: begin
				if (stack_cnt_q != '0) begin
					stk_re      = 1'b1;
					stk_raddr   = TABLE_AW'(stack_cnt_q - ENTRY_W'(1));
					stack_cnt_d = stack_cnt_q - ENTRY_W'(1);
					state_d     = S_POP;
				end else if (stream_ended_q) begin
					emit        = 1'b1;
					emit_status = ST_END;
				end else if (bit_cnt_q < CNT_W'(code_width_q)) begin
					emit        = 1'b1;
					emit_status = ST_NEED;
				end else begin
					bit_buf_d = bit_buf_q >> code_width_q;
					bit_cnt_d = bit_cnt_q - CNT_W'(code_width_q);
					if (code_width_q < MAX_WIDTH &&
					    next_entry_q == (ENTRY_W'(1) << code_width_q) - ENTRY_W'(1)) begin
						code_width_d = code_width_q + WIDTH_W'(1);
					end
					if (code_ext == CLR_CODE) begin
						code_width_d  = START_WIDTH;
						next_entry_d  = FIRST_FREE;
						after_clear_d = 1'b1;
					end else if (code_ext == END_CODE || code_ext > next_entry_q ||
					             (code_ext == next_entry_q &&
					              (after_clear_q || next_entry_q >= TABLE_FULL))) begin
						stream_ended_d = 1'b1;
					end else begin
						code_d  = code;
						tbl_re  = 1'b1;
						state_d = S_WALK;
						if (code_ext == next_entry_q) begin
							// string of the new code is the previous string plus its first byte
							stk_we      = 1'b1;
							stk_waddr   = '0;
							stk_wdata   = prev_first_q;
							stack_cnt_d = ENTRY_W'(1);
							walk_addr_d = prev_code_q;
							tbl_raddr   = TABLE_AW'(prev_code_q);
						end else begin
							stack_cnt_d = '0;
							walk_addr_d = code;
							tbl_raddr   = TABLE_AW'(code);
						end
					end
				end
			end
			S_WALK: begin
				stk_we      = 1'b1;
				stk_waddr   = TABLE_AW'(stack_cnt_q);
				stk_wdata   = walk_suffix;
				stack_cnt_d = stack_cnt_q + ENTRY_W'(1);
				if (walk_root) begin
					// root reached: its byte is the first byte of the decoded string
					if (!after_clear_q && next_entry_q < TABLE_FULL) begin
						tbl_we           = 1'b1;
						tbl_waddr        = TABLE_AW'(next_entry_q);
						tbl_wdata.prefix = prev_code_q;
						tbl_wdata.suffix = walk_suffix;
						next_entry_d     = next_entry_q + ENTRY_W'(1);
					end
					after_clear_d = 1'b0;
					prev_code_d   = code_q;
					prev_first_d  = walk_suffix;
					state_d       = S_PULL;
				end else begin
					tbl_re      = 1'b1;
					tbl_raddr   = TABLE_AW'(tbl_rdata.prefix);
					walk_addr_d = tbl_rdata.prefix;
				end
			end
			S_POP: begin
				emit        = 1'b1;
				emit_status = ST_PIXEL;
				emit_pixel  = stk_rdata;
			end
			S_EMIT: begin
				if (out_free) begin
					out_valid_d = 1'b1;
					status_d    = res_status_q;
					pixel_d     = res_pixel_q;
					state_d     = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase

		if (state_q != S_EMIT) begin
			if (emit && out_free) begin
				out_valid_d = 1'b1;
				status_d    = emit_status;
				pixel_d     = emit_pixel;
				state_d     = S_IDLE;
			end else if (emit) begin
				// hold the result until the receiver frees the output register
				res_status_d = emit_status;
				res_pixel_d  = emit_pixel;
				state_d      = S_EMIT;
				if (!out_stall) begin
					out_valid_d = 1'b0;
				end
			end else if (!out_stall) begin
				out_valid_d = 1'b0;
			end
		end else if (!out_free) begin
			out_valid_d = out_valid_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			bit_buf_q      <= '0;
			bit_cnt_q      <= '0;
			code_width_q   <= START_WIDTH;
			next_entry_q   <= FIRST_FREE;
			prev_code_q    <= '0;
			prev_first_q   <= '0;
			after_clear_q  <= 1'b0;
			stream_ended_q <= 1'b0;
			stack_cnt_q    <= '0;
			out_valid_q    <= 1'b0;
		end else begin
			state_q        <= state_d;
			bit_buf_q      <= bit_buf_d;
			bit_cnt_q      <= bit_cnt_d;
			code_width_q   <= code_width_d;
			next_entry_q   <= next_entry_d;
			prev_code_q    <= prev_code_d;
			prev_first_q   <= prev_first_d;
			after_clear_q  <= after_clear_d;
			stream_ended_q <= stream_ended_d;
			stack_cnt_q    <= stack_cnt_d;
			out_valid_q    <= out_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		code_q       <= code_d;
		walk_addr_q  <= walk_addr_d;
		res_status_q <= res_status_d;
		res_pixel_q  <= res_pixel_d;
		status_q     <= status_d;
		pixel_q      <= pixel_d;
	end

endmodule
